// ===== hw/rtl/dtd_pkg.sv =====
`default_nettype none
package dtd_pkg;

    // Characters of the number text
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIGITS   = 2'd1;
    localparam logic [1:0] ST_EXPONENT = 2'd2;

    localparam int POW_COUNT = 23;
    localparam logic signed [11:0] EXP_BIAS = 12'sd1023;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_INT,
        PH_FRAC,
        PH_ESIGN,
        PH_EDIG,
        PH_STOP
    } dtd_phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_NORM,
        BK_DIV,
        BK_MUL,
        BK_RND,
        BK_DONE
    } dtd_bstate_t;

    // One parsed string, handed from the parser to the arithmetic unit
    typedef struct packed {
        logic [49:0] mant;
        logic [4:0]  frac;
        logic [4:0]  emag;
        logic        vneg;
        logic        eneg;
        logic [1:0]  err;
    } dtd_rec_t;

    typedef logic [52:0] pow_sig_arr_t [POW_COUNT];
    typedef logic [7:0]  pow_exp_arr_t [POW_COUNT];

    // 10^k = 5^k * 2^k, so every entry is exact in a 53-bit significand
    function automatic pow_sig_arr_t gen_pow_sig();
        pow_sig_arr_t t;
        logic [52:0]  p;
        for (int k = 0; k < POW_COUNT; k++)
        begin
            p = 53'd1;
            for (int i = 0; i < k; i++)
                p = p * 53'd5;
            for (int j = 0; j < 53; j++)
                if (!p[52])
                    p = {p[51:0], 1'b0};
            t[k] = p;
        end
        return t;
    endfunction

    function automatic pow_exp_arr_t gen_pow_exp();
        pow_exp_arr_t t;
        logic [52:0]  p;
        int           sh;
        for (int k = 0; k < POW_COUNT; k++)
        begin
            p  = 53'd1;
            sh = 0;
            for (int i = 0; i < k; i++)
                p = p * 53'd5;
            for (int j = 0; j < 53; j++)
                if (!p[52])
                begin
                    p  = {p[51:0], 1'b0};
                    sh = sh + 1;
                end
            t[k] = 8'(k + 52 - sh);
        end
        return t;
    endfunction

    localparam pow_sig_arr_t POW_SIG = gen_pow_sig();
    localparam pow_exp_arr_t POW_EXP = gen_pow_exp();

endpackage
`default_nettype wire

// ===== hw/rtl/dtd_front.sv =====
`default_nettype none
module dtd_front
    import dtd_pkg::*;
#(
    parameter int MAX_DIGITS   = 15,
    parameter int MAX_EXPONENT = 22
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] ch,
    input  wire logic       last,
    output logic            push,
    output dtd_rec_t        push_rec
);

    dtd_phase_t  phase_reg, phase_next;
    logic [49:0] mant_reg, mant_next;
    logic [4:0]  dcnt_reg, dcnt_next;
    logic [4:0]  frac_reg, frac_next;
    logic [4:0]  emag_reg, emag_next;
    logic        vneg_reg, vneg_next;
    logic        eneg_reg, eneg_next;
    logic [1:0]  err_reg, err_next;

    logic        is_digit, is_space, is_e, is_sign, dig_ok, dig_taken;
    logic [3:0]  digit;
    logic [7:0]  ev;

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign is_e     = (ch == CH_LOW_E) || (ch == CH_UP_E);
    assign is_sign  = (ch == CH_MINUS) || (ch == CH_PLUS);
    assign digit    = 4'(ch - CH_ZERO);
    assign dig_ok   = dcnt_reg < 5'(MAX_DIGITS);
    assign ev       = ({3'b0, emag_reg} << 3) + ({3'b0, emag_reg} << 1) + {4'b0, digit};

    always_comb
    begin
        phase_next = phase_reg;
        mant_next  = mant_reg;
        dcnt_next  = dcnt_reg;
        frac_next  = frac_reg;
        emag_next  = emag_reg;
        vneg_next  = vneg_reg;
        eneg_next  = eneg_reg;
        err_next   = err_reg;
        dig_taken  = 1'b0;

        unique case (phase_reg)
            PH_SPACE:
            begin
                priority if (is_space)
                begin
                end
                else if (is_sign)
                begin
                    vneg_next  = (ch == CH_MINUS);
                    phase_next = PH_INT;
                end
                else if (is_digit)
                begin
                    dig_taken  = 1'b1;
                    phase_next = PH_INT;
                end
                else if (ch == CH_POINT)
                    phase_next = PH_FRAC;
                else if (is_e)
                    phase_next = PH_ESIGN;
                else
                    phase_next = PH_STOP;
            end
            PH_INT:
            begin
                priority if (is_digit)
                    dig_taken = 1'b1;
                else if (ch == CH_POINT)
                    phase_next = PH_FRAC;
                else if (is_e)
                    phase_next = PH_ESIGN;
                else
                    phase_next = PH_STOP;
            end
            PH_FRAC:
            begin
                priority if (is_digit)
                begin
                    dig_taken = 1'b1;
                    if (dig_ok)
                        frac_next = frac_reg + 5'd1;
                end
                else if (is_e)
                    phase_next = PH_ESIGN;
                else
                    phase_next = PH_STOP;
            end
            PH_ESIGN:
            begin
                priority if (is_sign)
                begin
                    eneg_next  = (ch == CH_MINUS);
                    phase_next = PH_EDIG;
                end
                else if (is_digit)
                begin
                    if (ev > 8'(MAX_EXPONENT))
                    begin
                        if (err_reg == ST_OK)
                            err_next = ST_EXPONENT;
                    end
                    else
                        emag_next = ev[4:0];
                    phase_next = PH_EDIG;
                end
                else
                    phase_next = PH_STOP;
            end
            PH_EDIG:
            begin
                if (is_digit)
                begin
                    if (ev > 8'(MAX_EXPONENT))
                    begin
                        if (err_reg == ST_OK)
                            err_next = ST_EXPONENT;
                    end
                    else
                        emag_next = ev[4:0];
                end
                else
                    phase_next = PH_STOP;
            end
            default:
                phase_next = PH_STOP;
        endcase

        if (dig_taken)
        begin
            if (dig_ok)
            begin
                mant_next = (mant_reg << 3) + (mant_reg << 1) + {46'b0, digit};
                dcnt_next = dcnt_reg + 5'd1;
            end
            else if (err_reg == ST_OK)
                err_next = ST_DIGITS;
        end
    end

    assign push = accept && last;
    always_comb
    begin
        push_rec.mant = mant_next;
        push_rec.frac = frac_next;
        push_rec.emag = emag_next;
        push_rec.vneg = vneg_next;
        push_rec.eneg = eneg_next;
        push_rec.err  = err_next;
    end

    // Start a fresh string after the last character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            mant_reg  <= '0;
            dcnt_reg  <= '0;
            frac_reg  <= '0;
            emag_reg  <= '0;
            vneg_reg  <= 1'b0;
            eneg_reg  <= 1'b0;
            err_reg   <= ST_OK;
        end
        else if (accept)
        begin
            if (last)
            begin
                phase_reg <= PH_SPACE;
                mant_reg  <= '0;
                dcnt_reg  <= '0;
                frac_reg  <= '0;
                emag_reg  <= '0;
                vneg_reg  <= 1'b0;
                eneg_reg  <= 1'b0;
                err_reg   <= ST_OK;
            end
            else
            begin
                phase_reg <= phase_next;
                mant_reg  <= mant_next;
                dcnt_reg  <= dcnt_next;
                frac_reg  <= frac_next;
                emag_reg  <= emag_next;
                vneg_reg  <= vneg_next;
                eneg_reg  <= eneg_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dtd_fifo.sv =====
`default_nettype none
module dtd_fifo
    import dtd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire dtd_rec_t push_rec,
    output logic          full,
    input  wire logic     pop,
    output dtd_rec_t      pop_rec,
    output logic          empty
);

    dtd_rec_t   mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign pop_rec = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wptr_reg <= !wptr_reg;
            if (pop && !empty)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, pop && !empty};
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/dtd_back.sv =====
`default_nettype none
module dtd_back
    import dtd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dtd_rec_t    pop_rec,
    input  wire logic        empty,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [65:0]      out_data
);

    dtd_bstate_t state_reg, state_next;

    logic [52:0]         sa_reg, sa_next;
    logic signed [11:0]  ea_reg, ea_next;
    logic [52:0]         sb_reg, sb_next;
    logic signed [11:0]  eb_reg, eb_next;
    logic [53:0]         rem_reg, rem_next;
    logic [54:0]         quo_reg, quo_next;
    logic [105:0]        acc_reg, acc_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic                second_reg, second_next;
    logic                ismul_reg, ismul_next;
    logic                eneg_reg, eneg_next;
    logic [4:0]          emag_reg, emag_next;
    logic                vneg_reg, vneg_next;
    logic [1:0]          err_reg, err_next;
    logic                zero_reg, zero_next;
    logic                ov_reg, ov_next;
    logic [65:0]         od_reg, od_next;

    logic                ge, mbit, up, g, s, can_write;
    logic [53:0]         diff;
    logic [52:0]         sig, sig_r;
    logic [53:0]         sum;
    logic signed [11:0]  e_pre, e_r, biased;
    logic [63:0]         bits;

    assign can_write = !ov_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (!empty)
                    state_next = ((pop_rec.err != ST_OK) || (pop_rec.mant == '0))
                               ? BK_DONE : BK_NORM;
            BK_NORM:
                if (sa_reg[52])
                    state_next = BK_DIV;
            BK_DIV:
                if (cnt_reg == 6'd54)
                    state_next = BK_RND;
            BK_MUL:
                if (cnt_reg == 6'd52)
                    state_next = BK_RND;
            BK_RND:
                if (second_reg)
                    state_next = BK_DONE;
                else
                    state_next = eneg_reg ? BK_DIV : BK_MUL;
            BK_DONE:
                if (can_write)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Rounding of the finished quotient or product
    always_comb
    begin
        if (ismul_reg)
        begin
            if (acc_reg[105])
            begin
                sig   = acc_reg[105:53];
                g     = acc_reg[52];
                s     = |acc_reg[51:0];
                e_pre = ea_reg + eb_reg + 12'sd1;
            end
            else
            begin
                sig   = acc_reg[104:52];
                g     = acc_reg[51];
                s     = |acc_reg[50:0];
                e_pre = ea_reg + eb_reg;
            end
        end
        else
        begin
            if (quo_reg[54])
            begin
                sig   = quo_reg[54:2];
                g     = quo_reg[1];
                s     = quo_reg[0] || (rem_reg != '0);
                e_pre = ea_reg - eb_reg;
            end
            else
            begin
                sig   = quo_reg[53:1];
                g     = quo_reg[0];
                s     = (rem_reg != '0);
                e_pre = ea_reg - eb_reg - 12'sd1;
            end
        end
        up  = g && (s || sig[0]);
        sum = {1'b0, sig} + {53'b0, up};
        if (sum[53])
        begin
            sig_r = {1'b1, 52'b0};
            e_r   = e_pre + 12'sd1;
        end
        else
        begin
            sig_r = sum[52:0];
            e_r   = e_pre;
        end
    end

    assign ge     = rem_reg >= {1'b0, sb_reg};
    assign diff   = rem_reg - {1'b0, sb_reg};
    assign mbit   = sb_reg[6'd52 - cnt_reg];
    assign biased = ea_reg + EXP_BIAS;

    always_comb
    begin
        if (err_reg != ST_OK)
            bits = '0;
        else if (zero_reg)
            bits = {vneg_reg, 63'b0};
        else
            bits = {vneg_reg, biased[10:0], sa_reg[51:0]};
    end

    // Datapath and outputs
    always_comb
    begin
        pop         = 1'b0;
        sa_next     = sa_reg;
        ea_next     = ea_reg;
        sb_next     = sb_reg;
        eb_next     = eb_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        second_next = second_reg;
        ismul_next  = ismul_reg;
        eneg_next   = eneg_reg;
        emag_next   = emag_reg;
        vneg_next   = vneg_reg;
        err_next    = err_reg;
        zero_next   = zero_reg;
        ov_next     = ov_reg && !out_ready;
        od_next     = od_reg;

        unique case (state_reg)
            BK_IDLE:
                if (!empty)
                begin
                    pop         = 1'b1;
                    sa_next     = {3'b0, pop_rec.mant};
                    ea_next     = 12'sd52;
                    sb_next     = POW_SIG[pop_rec.frac];
                    eb_next     = {4'b0, POW_EXP[pop_rec.frac]};
                    eneg_next   = pop_rec.eneg;
                    emag_next   = pop_rec.emag;
                    vneg_next   = pop_rec.vneg;
                    err_next    = pop_rec.err;
                    zero_next   = (pop_rec.mant == '0);
                    second_next = 1'b0;
                    ismul_next  = 1'b0;
                end
            BK_NORM:
            begin
                if (!sa_reg[52])
                begin
                    sa_next = {sa_reg[51:0], 1'b0};
                    ea_next = ea_reg - 12'sd1;
                end
                rem_next = {1'b0, sa_reg};
                quo_next = '0;
                cnt_next = '0;
            end
            BK_DIV:
            begin
                quo_next = {quo_reg[53:0], ge};
                rem_next = ge ? {diff[52:0], 1'b0} : {rem_reg[52:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
            end
            BK_MUL:
            begin
                acc_next = {acc_reg[104:0], 1'b0} + (mbit ? {53'b0, sa_reg} : 106'b0);
                cnt_next = cnt_reg + 6'd1;
            end
            BK_RND:
            begin
                sa_next = sig_r;
                ea_next = e_r;
                if (!second_reg)
                begin
                    second_next = 1'b1;
                    sb_next     = POW_SIG[emag_reg];
                    eb_next     = {4'b0, POW_EXP[emag_reg]};
                    ismul_next  = !eneg_reg;
                    cnt_next    = '0;
                    rem_next    = {1'b0, sig_r};
                    quo_next    = '0;
                    acc_next    = '0;
                end
            end
            BK_DONE:
                if (can_write)
                begin
                    ov_next = 1'b1;
                    od_next = {err_reg, bits};
                end
            default:
            begin
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_ff @(posedge clk)
    begin
        sa_reg   <= sa_next;
        ea_reg   <= ea_next;
        sb_reg   <= sb_next;
        eb_reg   <= eb_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        acc_reg  <= acc_next;
        cnt_reg  <= cnt_next;
        eneg_reg <= eneg_next;
        emag_reg <= emag_next;
        vneg_reg <= vneg_next;
        err_reg  <= err_next;
        zero_reg <= zero_next;
        od_reg   <= od_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            second_reg <= 1'b0;
            ismul_reg  <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            ismul_reg  <= ismul_next;
            ov_reg     <= ov_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/decimal_text_to_double_top.sv =====
`default_nettype none
// Decimal text to IEEE double.
// Input stream: one ASCII character per item on s_tdata[7:0]; s_tlast marks the
// final character of a number string. Leading whitespace, sign, integer and
// fraction digits and an e/E exponent are parsed; parsing stops at the first
// character that does not fit.
// Output stream: one item per string on m_tdata, holding the double bit pattern
// and a status (0 ok, 1 too many digits, 2 exponent too large; the value is
// zero on error).
// Throughput: one character per cycle while the record queue has room.
// The arithmetic unit, per string, takes the record, normalises it by shifting,
// runs a restoring divide by the power of ten of the fraction digits, rounds,
// then runs a shift-add multiply or a restoring divide by the power of ten of
// the exponent, rounds again and loads the output register.
// Zero values and errors skip the arithmetic.
// A two-entry record queue parts the parser from the arithmetic unit, so
// characters of the next strings keep flowing while one is computed.
// Reset clears the parser, the queue and the output valid flag, not the output data.
// When the receiver stalls, the output item is held, the arithmetic unit waits
// and s_tready drops once the queue is full.
module decimal_text_to_double_top
    import dtd_pkg::*;
#(
    parameter int MAX_DIGITS   = 15,
    parameter int MAX_EXPONENT = 22
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [63:0] value_bits, [65:64] status, rest zero
);

    logic     accept, push, full, pop, empty;
    dtd_rec_t push_rec, pop_rec;
    logic [65:0] out_data;

    // Hold off characters while the queue cannot take a finished string
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    dtd_front #(
        .MAX_DIGITS   (MAX_DIGITS),
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .ch       (s_tdata),
        .last     (s_tlast),
        .push     (push),
        .push_rec (push_rec)
    );

    dtd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (full),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .empty    (empty)
    );

    dtd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_rec   (pop_rec),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {6'b0, out_data};

endmodule
`default_nettype wire
